// ===== rtl/fpd_pkg.sv =====
package fpd_pkg;

  // Width of every coordinate, track index and register field on the ports.
  localparam int FIELD_BITS = 16;

  // Default sizing of the point store and of the coordinate datapath.
  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  // Width of the squared radius, computed from a 16-bit limit.
  localparam int LIM_SQ_BITS = 2 * FIELD_BITS;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISTANCE_LIMIT  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_NEW_INDEX = CFG_INDEX_BITS'(1);

  localparam logic [FIELD_BITS-1:0] RESET_DISTANCE_LIMIT  = FIELD_BITS'(160);
  localparam logic [FIELD_BITS-1:0] RESET_FIRST_NEW_INDEX = FIELD_BITS'(0);

  // Action codes carried by an input word.
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_TEST  = 2'd2
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic                  kept;
    logic [FIELD_BITS-1:0] kept_x;
    logic [FIELD_BITS-1:0] kept_y;
    logic [FIELD_BITS-1:0] new_index;
    logic                  store_full;
  } result_t;

endpackage

// ===== rtl/feature_point_dedup_top.sv =====
// Radius-based deduplication of feature points. Tracked points are loaded
// into an on-chip store with load words; each test word then carries a
// candidate that is compared against every stored point, and the candidate
// is kept only when no stored point lies within distance_limit (all
// coordinates are unsigned Q12.4, and the test is dx*dx + dy*dy against the
// squared limit, exact, with no root). A kept candidate is returned with
// track index first_new_index + kept count, modulo 65536; it is not added to
// the store. A clear word empties the store and the kept count. Every input
// word gives exactly one result word, and fields that carry no meaning for
// the action are zero. A load into a full store is dropped and flagged with
// store_full. Clear and load words are answered straight from the idle
// state. A test word walks the store through one shared distance pipeline,
// one stored point per cycle, and its result word is loaded once the
// output register is free; a close point found early stops the walk, but
// the pipeline still drains before the result is issued. The block does
// not take a new word while a test is running.
// The store has no reset pass: only entries below the fill count are read.
// Configuration registers may be written at any time the block is idle;
// cfg_ready is always high.
module feature_point_dedup_top #(
  parameter int MAX_POINTS = fpd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = fpd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  fpd_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output fpd_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpd_pkg::FIELD_BITS-1:0]      cfg_data
);

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int FB   = fpd_pkg::FIELD_BITS;
  localparam int LSQ  = fpd_pkg::LIM_SQ_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FB-1:0] distance_limit;
  logic [FB-1:0] first_new_index;

  // Point store.
  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic [COORD_BITS-1:0] rd_x, rd_y;

  // Sequencer and block state.
  logic [CNTW-1:0]       tracked_count;
  logic [FB-1:0]         kept_count;
  logic [CNTW-1:0]       issue_idx;
  logic                  rd_vld;
  logic                  close_found;
  logic [COORD_BITS-1:0] cand_x, cand_y;
  logic [LSQ-1:0]        lim_sq;

  logic                  accept;
  logic                  out_free;
  logic                  store_has_room;
  logic                  mem_we;
  logic                  issue;
  logic                  scan_done;
  logic                  res_load;
  fpd_pkg::result_t      load_word;
  fpd_pkg::result_t      test_word;
  logic [COORD_BITS-1:0] item_x_c, item_y_c;
  logic                  dist_busy, dist_hit_vld, dist_hit;

  // Coordinates are trimmed or widened to the datapath width.
  assign item_x_c = COORD_BITS'(item.point_x);
  assign item_y_c = COORD_BITS'(item.point_y);

  // The output register may be reloaded when it is empty or being taken.
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  assign store_has_room = tracked_count < CNTW'(MAX_POINTS);
  assign mem_we = accept && (item.action == fpd_pkg::ACT_LOAD) && store_has_room;

  // A result word is loaded for every clear, load or unused word at once,
  // and for a test word when its scan has finished.
  assign res_load = ((state == ST_IDLE) && accept && (item.action != fpd_pkg::ACT_TEST)) ||
                    ((state == ST_DONE) && out_free);

  // Stored points are fed one per cycle until the fill count is reached or
  // a close point has been seen.
  assign issue = (state == ST_SCAN) && !close_found && (issue_idx < tracked_count);

  // The scan ends only once the pipeline has drained, so no stale point
  // result can leak into the next test.
  assign scan_done = (state == ST_SCAN) && (close_found || (issue_idx == tracked_count)) &&
                     !rd_vld && !dist_busy;

  // Result words for a load and for a finished test.
  always_comb begin
    load_word            = '0;
    load_word.store_full = !store_has_room;
    test_word            = '0;
    if (!close_found) begin
      test_word.kept      = 1'b1;
      test_word.kept_x    = FB'(cand_x);
      test_word.kept_y    = FB'(cand_y);
      test_word.new_index = first_new_index + kept_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[tracked_count[AW-1:0]] <= item_x_c;
      mem_y[tracked_count[AW-1:0]] <= item_y_c;
    end
    rd_x <= mem_x[issue_idx[AW-1:0]];
    rd_y <= mem_y[issue_idx[AW-1:0]];
  end

  fpd_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (rd_vld),
    .cand_x  (cand_x),
    .cand_y  (cand_y),
    .trk_x   (rd_x),
    .trk_y   (rd_y),
    .lim_sq  (lim_sq),
    .busy    (dist_busy),
    .hit_vld (dist_hit_vld),
    .hit     (dist_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit  <= fpd_pkg::RESET_DISTANCE_LIMIT;
      first_new_index <= fpd_pkg::RESET_FIRST_NEW_INDEX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpd_pkg::REG_DISTANCE_LIMIT:  distance_limit  <= cfg_data;
        fpd_pkg::REG_FIRST_NEW_INDEX: first_new_index <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      tracked_count <= '0;
      kept_count    <= '0;
      issue_idx     <= '0;
      rd_vld        <= 1'b0;
      close_found   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        issue_idx <= issue_idx + CNTW'(1);
      end
      if (dist_hit_vld && dist_hit) begin
        close_found <= 1'b1;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.action)
              fpd_pkg::ACT_CLEAR: begin
                tracked_count <= '0;
                kept_count    <= '0;
                result        <= '0;
              end
              fpd_pkg::ACT_LOAD: begin
                result <= load_word;
                if (store_has_room) begin
                  tracked_count <= tracked_count + CNTW'(1);
                end
              end
              fpd_pkg::ACT_TEST: begin
                cand_x      <= item_x_c;
                cand_y      <= item_y_c;
                lim_sq      <= LSQ'(distance_limit) * LSQ'(distance_limit);
                issue_idx   <= '0;
                close_found <= 1'b0;
                state       <= ST_SCAN;
              end
              default: begin
                result <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result <= test_word;
            if (!close_found) begin
              kept_count <= kept_count + FB'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tracked_count <= CNTW'(MAX_POINTS))
    else $error("fill count ran past the store size");

  a_kept_not_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kept |-> !result.store_full)
    else $error("kept word also flags a full store");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.kept |->
      (result.kept_x == '0) && (result.kept_y == '0) && (result.new_index == '0))
    else $error("non-kept word carries candidate fields");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.store_full |-> tracked_count == CNTW'(MAX_POINTS))
    else $error("store_full flagged while the store has room");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |=> !$rose(result_valid))
    else $error("result word issued in the middle of a scan");

endmodule

// ===== rtl/fpd_dist.sv =====
// Pipelined squared-distance unit: absolute differences, squares, then the
// sum compared against the squared radius. One stored point enters per cycle.
module fpd_dist #(
  parameter int COORD_BITS = fpd_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [COORD_BITS-1:0]            cand_x,
  input  logic [COORD_BITS-1:0]            cand_y,
  input  logic [COORD_BITS-1:0]            trk_x,
  input  logic [COORD_BITS-1:0]            trk_y,
  input  logic [fpd_pkg::LIM_SQ_BITS-1:0]  lim_sq,
  output logic                             busy,
  output logic                             hit_vld,
  output logic                             hit
);

  localparam int SQW  = 2 * COORD_BITS;
  localparam int SUMW = SQW + 1;
  localparam int CMPW = (SUMW > fpd_pkg::LIM_SQ_BITS) ? SUMW : fpd_pkg::LIM_SQ_BITS;

  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQW-1:0]        sx, sy;
  logic                  close;
  logic [SUMW-1:0]       sum_sq;

  assign sum_sq = SUMW'(sx) + SUMW'(sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
    dx    <= (cand_x >= trk_x) ? (cand_x - trk_x) : (trk_x - cand_x);
    dy    <= (cand_y >= trk_y) ? (cand_y - trk_y) : (trk_y - cand_y);
    sx    <= SQW'(dx) * SQW'(dx);
    sy    <= SQW'(dy) * SQW'(dy);
    close <= CMPW'(sum_sq) <= CMPW'(lim_sq);
  end

  assign busy    = v1 || v2 || v3;
  assign hit_vld = v3;
  assign hit     = close;

endmodule

// ===== sim/tb_feature_point_dedup_top.sv =====
`timescale 1ns / 100ps

module tb_feature_point_dedup_top;

  // The store depth and the run limit. The slowest case is a test word that
  // walks a full store, with the idle gaps that sender and receiver draw on
  // each side. The limit lies far above the slowest correct run of this
  // stimulus.
  localparam int STORE_DEPTH = fpd_pkg::MAX_POINTS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int WORD_BUDGET = 810;
  localparam int SETTLE_CYCLES = 300;
  localparam int REPORT_MAX = 10;
  localparam int IW = fpd_pkg::CFG_INDEX_BITS;
  localparam int FB = fpd_pkg::FIELD_BITS;

  // Action code 3 has no member in the package enum; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Register indexes that do not exist; writes to them must change nothing.
  localparam logic [IW-1:0] REG_UNUSED_LOW  = IW'(2);
  localparam logic [IW-1:0] REG_UNUSED_HIGH = IW'(255);

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  fpd_pkg::item_t            item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  fpd_pkg::result_t          result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IW-1:0]             cfg_index = '0;
  logic [FB-1:0]             cfg_data = '0;

  feature_point_dedup_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the block state. It is updated when a word is accepted, so
  // it always matches what the block should hold after that word.
  logic [FB-1:0] trk_x [STORE_DEPTH];
  logic [FB-1:0] trk_y [STORE_DEPTH];
  int            trk_count = 0;
  logic [FB-1:0] kept_total = '0;
  logic [FB-1:0] radius_reg = fpd_pkg::RESET_DISTANCE_LIMIT;
  logic [FB-1:0] first_index_reg = fpd_pkg::RESET_FIRST_NEW_INDEX;

  // Result words still owed by the block, oldest first.
  fpd_pkg::result_t pending_results[$];

  // Run bookkeeping.
  int  cycle_count = 0;
  int  words_sent = 0;
  int  error_count = 0;
  int  kept_seen = 0;
  int  close_seen = 0;
  int  full_seen = 0;
  int  radius_writes = 0;
  bit  sender_burst = 1'b0;
  bit  receiver_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. A hang anywhere (a lost result, a stuck stall) ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words outstanding.",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Works out the result word for one accepted input word and advances the
  // shadow state. Closeness is dx*dx + dy*dy <= radius*radius, evaluated
  // exactly in 64 bits, which cannot overflow for 16-bit coordinates.
  function automatic fpd_pkg::result_t dedup_predict(input fpd_pkg::item_t w);
    fpd_pkg::result_t r;
    logic             close;
    logic [63:0]      dx;
    logic [63:0]      dy;
    logic [63:0]      radius_sq;
    r = '0;
    close = 1'b0;
    radius_sq = 64'(radius_reg) * 64'(radius_reg);
    case (w.action)
      fpd_pkg::ACT_CLEAR: begin
        trk_count = 0;
        kept_total = '0;
      end
      fpd_pkg::ACT_LOAD: begin
        if (trk_count < STORE_DEPTH) begin
          trk_x[trk_count] = w.point_x;
          trk_y[trk_count] = w.point_y;
          trk_count++;
        end else begin
          r.store_full = 1'b1;
        end
      end
      fpd_pkg::ACT_TEST: begin
        for (int i = 0; i < trk_count && !close; i++) begin
          dx = (w.point_x >= trk_x[i]) ? 64'(w.point_x - trk_x[i])
                                       : 64'(trk_x[i] - w.point_x);
          dy = (w.point_y >= trk_y[i]) ? 64'(w.point_y - trk_y[i])
                                       : 64'(trk_y[i] - w.point_y);
          if (dx * dx + dy * dy <= radius_sq) close = 1'b1;
        end
        if (!close) begin
          r.kept = 1'b1;
          r.kept_x = w.point_x;
          r.kept_y = w.point_y;
          r.new_index = first_index_reg + kept_total;
          kept_total = kept_total + 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sends one word. The sender draws its own idle gap first; after the word is
  // taken, valid stays high until the next falling edge, where the caller
  // either presents the next word or lowers valid.
  task automatic send_word(input logic [1:0] act, input logic [FB-1:0] x,
                           input logic [FB-1:0] y);
    fpd_pkg::item_t   w;
    fpd_pkg::result_t r;
    int               gap;
    w.action = fpd_pkg::action_t'(act);
    w.point_x = x;
    w.point_y = y;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    r = dedup_predict(w);
    pending_results.push_back(r);
    if (w.action == fpd_pkg::ACT_TEST && !r.kept) close_seen++;
    words_sent++;
  endtask

  // Lowers valid and waits until the block has returned every result word.
  // Every word gives a result, so an empty queue means the block is idle.
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [FB-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fpd_pkg::REG_DISTANCE_LIMIT) begin
      radius_reg = value;
      radius_writes++;
    end else if (idx == fpd_pkg::REG_FIRST_NEW_INDEX) begin
      first_index_reg = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [FB-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[FB-1:0];
  endfunction

  function automatic logic [FB-1:0] any_coord();
    return FB'($urandom_range(0, 65535));
  endfunction

  // A candidate scattered around a random stored point, within about one
  // radius on each axis, so that both outcomes are common.
  task automatic send_near_candidate();
    int slot;
    int span;
    int ox;
    int oy;
    if (trk_count == 0) begin
      send_word(fpd_pkg::ACT_TEST, any_coord(), any_coord());
    end else begin
      slot = $urandom_range(0, trk_count - 1);
      span = int'(radius_reg) + 2;
      ox = int'($urandom_range(0, 2 * span)) - span;
      oy = int'($urandom_range(0, 2 * span)) - span;
      send_word(fpd_pkg::ACT_TEST, clamp_coord(int'(trk_x[slot]) + ox),
                clamp_coord(int'(trk_y[slot]) + oy));
    end
  endtask

  // A candidate exactly on the radius along one axis, or one step beyond it.
  task automatic send_boundary_candidate();
    int slot;
    int reach;
    if (trk_count == 0) begin
      send_word(fpd_pkg::ACT_TEST, any_coord(), any_coord());
    end else begin
      slot = $urandom_range(0, trk_count - 1);
      reach = int'(radius_reg) + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) reach = -reach;
      if ($urandom_range(0, 1))
        send_word(fpd_pkg::ACT_TEST, clamp_coord(int'(trk_x[slot]) + reach), trk_y[slot]);
      else
        send_word(fpd_pkg::ACT_TEST, trk_x[slot], clamp_coord(int'(trk_y[slot]) + reach));
    end
  endtask

  // Result side. For every word the receiver draws a random stall, holds stall
  // high for that stall, then takes the next word as soon as it shows.
  // Stall changes only at falling edges, at most once per edge.
  initial begin : result_receiver
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = receiver_burst ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  // Compares each accepted result word with the oldest outstanding prediction.
  always @(posedge clk) begin : result_checker
    fpd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("Unexpected result word at cycle %0d: %p", cycle_count, result);
      end else begin
        want = pending_results.pop_front();
        if (result.kept !== want.kept || result.kept_x !== want.kept_x ||
            result.kept_y !== want.kept_y || result.new_index !== want.new_index ||
            result.store_full !== want.store_full) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("Mismatch at cycle %0d: expected kept=%0b x=%h y=%h idx=%h full=%0b",
                     cycle_count, want.kept, want.kept_x, want.kept_y, want.new_index,
                     want.store_full);
            $display("  got kept=%0b x=%h y=%h idx=%h full=%0b",
                     result.kept, result.kept_x, result.kept_y, result.new_index,
                     result.store_full);
          end
        end
        if (want.kept) kept_seen++;
        if (want.store_full) full_seen++;
      end
    end
  end

  // Hand-picked words under the reset settings (radius 160, first index 0):
  // the empty store, the unused action, both corners of the coordinate range,
  // candidates exactly on the radius and one step past it, and a clear.
  task automatic test_directed_cases();
    send_word(fpd_pkg::ACT_TEST, 16'd500, 16'd500);
    send_word(ACT_UNUSED, 16'd1234, 16'd4321);
    send_word(fpd_pkg::ACT_LOAD, 16'h0000, 16'h0000);
    send_word(fpd_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF);
    send_word(fpd_pkg::ACT_TEST, 16'h0000, 16'h0000);
    send_word(fpd_pkg::ACT_TEST, 16'd160, 16'd0);
    send_word(fpd_pkg::ACT_TEST, 16'd161, 16'd0);
    send_word(fpd_pkg::ACT_TEST, 16'd0, 16'd160);
    send_word(fpd_pkg::ACT_TEST, 16'd113, 16'd113);
    send_word(fpd_pkg::ACT_TEST, 16'd114, 16'd113);
    send_word(fpd_pkg::ACT_TEST, 16'hFFFF - 16'd160, 16'hFFFF);
    send_word(fpd_pkg::ACT_TEST, 16'hFFFF, 16'h0000);
    send_word(fpd_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    send_word(fpd_pkg::ACT_TEST, 16'h0000, 16'h0000);
    send_word(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
  endtask

  // Both registers at their extremes, writes to indexes that do not exist, and
  // the track index wrapping past 65535.
  task automatic test_register_extremes();
    drain_results();
    write_reg(fpd_pkg::REG_DISTANCE_LIMIT, 16'h0000);
    write_reg(fpd_pkg::REG_FIRST_NEW_INDEX, 16'hFFFF);
    write_reg(REG_UNUSED_LOW, 16'h0007);
    write_reg(REG_UNUSED_HIGH, 16'hFFFF);
    send_word(fpd_pkg::ACT_CLEAR, 16'h0000, 16'h0000);
    send_word(fpd_pkg::ACT_LOAD, 16'd100, 16'd100);
    send_word(fpd_pkg::ACT_TEST, 16'd100, 16'd100);
    send_word(fpd_pkg::ACT_TEST, 16'd101, 16'd100);
    send_word(fpd_pkg::ACT_TEST, 16'd0, 16'd0);
    drain_results();
    write_reg(fpd_pkg::REG_DISTANCE_LIMIT, 16'hFFFF);
    write_reg(fpd_pkg::REG_FIRST_NEW_INDEX, 16'h1234);
    send_word(fpd_pkg::ACT_TEST, 16'hFFFF, 16'hFFFF);
    send_word(fpd_pkg::ACT_TEST, 16'hFFFF, 16'd100);
    send_word(fpd_pkg::ACT_TEST, 16'h0000, 16'hFFFF);
    send_word(fpd_pkg::ACT_LOAD, 16'h0000, 16'h0000);
    send_word(fpd_pkg::ACT_TEST, 16'hFFFF, 16'hFFFF);
    drain_results();
    write_reg(fpd_pkg::REG_DISTANCE_LIMIT, fpd_pkg::RESET_DISTANCE_LIMIT);
    write_reg(fpd_pkg::REG_FIRST_NEW_INDEX, fpd_pkg::RESET_FIRST_NEW_INDEX);
  endtask

  // Fills the store to the last entry, then pushes loads that must be refused
  // and tests that walk the whole store, including a match in the last entry.
  task automatic test_store_full();
    drain_results();
    write_reg(fpd_pkg::REG_DISTANCE_LIMIT, FB'($urandom_range(4, 64)));
    send_word(fpd_pkg::ACT_CLEAR, any_coord(), any_coord());
    for (int i = 0; i < STORE_DEPTH; i++)
      send_word(fpd_pkg::ACT_LOAD, any_coord(), any_coord());
    send_word(fpd_pkg::ACT_LOAD, any_coord(), any_coord());
    send_word(fpd_pkg::ACT_LOAD, 16'hFFFF, 16'h0000);
    send_word(fpd_pkg::ACT_TEST, trk_x[STORE_DEPTH-1], trk_y[STORE_DEPTH-1]);
    for (int i = 0; i < 5; i++) send_near_candidate();
    for (int i = 0; i < 4; i++) send_word(fpd_pkg::ACT_TEST, any_coord(), any_coord());
    send_word(fpd_pkg::ACT_CLEAR, 16'h0000, 16'h0000);
  endtask

  // Phases of random traffic. Each phase picks new settings, clears the store,
  // loads points, about half in a small cluster, then mostly tests candidates
  // around them, with stray loads, clears, unused actions and random points.
  task automatic test_random_traffic();
    int phase;
    int loads;
    int words;
    int pick;
    int cx;
    int cy;
    int spread;
    phase = 0;
    while (words_sent < WORD_BUDGET) begin
      drain_results();
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(fpd_pkg::REG_DISTANCE_LIMIT, 16'h0000);
      else if (pick == 1) write_reg(fpd_pkg::REG_DISTANCE_LIMIT, 16'hFFFF);
      else if (pick == 2) write_reg(fpd_pkg::REG_DISTANCE_LIMIT, any_coord());
      else write_reg(fpd_pkg::REG_DISTANCE_LIMIT, FB'($urandom_range(1, 400)));
      if ($urandom_range(0, 3) == 0)
        write_reg(fpd_pkg::REG_FIRST_NEW_INDEX, 16'hFFFF - FB'($urandom_range(0, 8)));
      else
        write_reg(fpd_pkg::REG_FIRST_NEW_INDEX, any_coord());
      sender_burst = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);

      send_word(fpd_pkg::ACT_CLEAR, any_coord(), any_coord());
      cx = $urandom_range(0, 65535);
      cy = $urandom_range(0, 65535);
      spread = 4 * (int'(radius_reg) + 8);
      loads = $urandom_range(1, 24);
      for (int i = 0; i < loads; i++) begin
        if ($urandom_range(0, 1))
          send_word(fpd_pkg::ACT_LOAD, any_coord(), any_coord());
        else
          send_word(fpd_pkg::ACT_LOAD,
                    clamp_coord(cx + int'($urandom_range(0, 2 * spread)) - spread),
                    clamp_coord(cy + int'($urandom_range(0, 2 * spread)) - spread));
      end

      words = $urandom_range(10, 40);
      for (int i = 0; i < words; i++) begin
        // In the third phase, hold off once mid-phase until the block has answered everything.
        if (phase == 2 && i == words / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 55) send_near_candidate();
        else if (pick < 65) send_boundary_candidate();
        else if (pick < 80) send_word(fpd_pkg::ACT_TEST, any_coord(), any_coord());
        else if (pick < 88) send_word(fpd_pkg::ACT_LOAD, any_coord(), any_coord());
        else if (pick < 92) send_word(fpd_pkg::ACT_CLEAR, any_coord(), any_coord());
        else send_word(ACT_UNUSED, any_coord(), any_coord());
      end
      phase++;
    end
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_store_full();
    test_random_traffic();

    // Let the block finish, then watch a while longer for stray result words.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    error_count += pending_results.size();

    $display("Sent %0d words over %0d radius settings; %0d kept, %0d dropped as close.",
             words_sent, radius_writes, kept_seen, close_seen);
    $display("Loads refused on a full store: %0d; errors: %0d; cycles: %0d.",
             full_seen, error_count, cycle_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
